// ===== rtl/core/srm_pkg.sv =====
// Package: types, constants and request codes for the step response metrics block.
package srm_pkg;

   localparam int MaxSamples = 1024;
   localparam int AddrW = $clog2(MaxSamples);
   localparam int CountW = $clog2(MaxSamples + 1);
   localparam logic [15:0] BandRatioReset = 16'd3277;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        sample_time;
      logic signed [15:0] sample_value;
   } req_type_type;

   typedef struct packed {
      logic signed [15:0] steady_level;
      logic signed [31:0] overshoot_ratio;
      logic               overshoot_valid;
      logic [31:0]        settle_time;
      logic               settle_found;
      logic               store_overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN,
      ST_RATIO,
      ST_BAND,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/core/srm_divider.sv =====
// Divider: unsigned restoring division, one quotient bit per cycle.
module srm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import srm_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[63]} - {2'b00, div_ff};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/core/step_response_metrics_top.sv =====
// Top level: sample record, peak tracking and query engine for step response metrics.
//
// Usage:
//   req_ channel carries transactions: add sample, query metrics or clear.
//   rsp_ channel returns one transaction per query; add and clear give none.
//   csr_ port writes the settling band ratio (unsigned Q0.16); the user writes it only
//   while idle, as the block itself does not enforce this.
// Sequencing:
//   Adds and clears are taken while idle; adds run back to back between queries.
//   A query runs two divisions (mean after a peak, overshoot ratio when valid) in one
//   shared bit-serial divider, then scans the sample memories at one entry per cycle.
//   req_stall is high from the acceptance of a query until its result is loaded.
// Reset:
//   Synchronous, active high; clears the record and restores ratio 3277.
//   The sample memories are not cleared; only entries below the count are read.
// Stall:
//   The result is held stable in the output register while rsp_stall is high;
//   a further query waits in its output step, with req_stall high, until it is taken.
module step_response_metrics_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  srm_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srm_pkg::rsp_type      rsp_data,
   input  logic                  csr_write,
   input  logic [15:0]           csr_data
);
   import srm_pkg::*;

   logic [31:0] time_mem [MaxSamples];
   logic signed [15:0] value_mem [MaxSamples];
   logic [31:0] time_rd_ff;
   logic signed [15:0] value_rd_ff;
   logic [AddrW-1:0] rd_addr;

   state_type state_ff, state_in;
   logic [15:0] ratio_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic signed [15:0] max_ff, max_in;
   logic signed [26:0] sum_ff, sum_in;
   logic [CountW-1:0] run_cnt_ff, run_cnt_in;
   logic peak_ff, peak_in;
   logic signed [15:0] prev_ff, prev_in;
   logic [1:0] slope_ff, slope_in;
   logic ovf_ff, ovf_in;

   logic signed [15:0] steady_ff, steady_in;
   logic signed [31:0] oratio_ff, oratio_in;
   logic signed [48:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CountW-1:0] idx_ff, idx_in;
   logic in_run_ff, in_run_in;
   logic [31:0] start_ff, start_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept, do_add, wr_en;
   logic neg_ff, neg_in;
   logic div_start;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic div_done;
   logic [63:0] div_q;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign do_add = accept && req_data.req_type == REQ_ADD;
   assign wr_en = do_add && count_ff < CountW'(MaxSamples);

   srm_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[count_ff[AddrW-1:0]]  <= req_data.sample_time;
         value_mem[count_ff[AddrW-1:0]] <= req_data.sample_value;
      end
      time_rd_ff  <= time_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   assign rd_addr = idx_ff[AddrW-1:0];

   // sample update
   always_comb begin
      logic signed [1:0] s;
      count_in   = count_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      run_cnt_in = run_cnt_ff;
      peak_in    = peak_ff;
      prev_in    = prev_ff;
      slope_in   = slope_ff;
      ovf_in     = ovf_ff;
      s          = '0;
      if (accept && req_data.req_type == REQ_CLEAR) begin
         count_in = '0; max_in = 16'sh8000; sum_in = '0; run_cnt_in = '0;
         peak_in = 1'b0; prev_in = '0; slope_in = 2'b01; ovf_in = 1'b0;
      end else if (do_add && !wr_en) begin
         ovf_in = 1'b1;
      end else if (wr_en) begin
         if (count_ff != '0) begin
            s = (req_data.sample_value > prev_ff) ? 2'sb01 :
                (req_data.sample_value < prev_ff) ? 2'sb11 : 2'sb00;
            if ((s == 2'sb01 && slope_ff == 2'b11) || (s == 2'sb11 && slope_ff == 2'b01)) begin
               peak_in = 1'b1; sum_in = '0; run_cnt_in = '0;
            end
            slope_in = s;
         end
         count_in = count_ff + 1'b1;
         if (req_data.sample_value > max_ff) max_in = req_data.sample_value;
         if (peak_in) begin
            sum_in = sum_in + 27'(req_data.sample_value);
            run_cnt_in = run_cnt_in + 1'b1;
         end
         prev_in = req_data.sample_value;
      end
   end

   // query sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept && req_data.req_type == REQ_QUERY) state_in = ST_MEAN;
         ST_MEAN:      if (div_done || !(peak_ff && run_cnt_ff != '0)) state_in = ST_RATIO;
         ST_RATIO:     if (div_done || count_ff == '0 || steady_ff == '0) state_in = ST_BAND;
         ST_BAND:      state_in = (count_ff == '0) ? ST_OUT : ST_SCAN;
         ST_SCAN:      if (idx_ff + 1'b1 >= count_ff) state_in = ST_SCAN_LAST;
         ST_SCAN_LAST: state_in = ST_OUT;
         ST_OUT:       if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   logic div_busy_ff, div_busy_in;
   logic signed [63:0] num;
   logic signed [63:0] q_s;
   logic signed [48:0] x;

   // query sequencer: datapath and outputs
   always_comb begin
      steady_in = steady_ff; oratio_in = oratio_ff; lo_in = lo_ff; hi_in = hi_ff;
      idx_in = idx_ff; in_run_in = in_run_ff; start_in = start_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff; neg_in = neg_ff;
      div_start = 1'b0; div_dividend = '0; div_divisor = '0;
      div_busy_in = div_busy_ff;
      num = '0; q_s = '0;
      x = 49'(value_rd_ff) <<< 16;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            steady_in = prev_ff; oratio_in = '0; div_busy_in = 1'b0;
         end
         ST_MEAN: if (peak_ff && run_cnt_ff != '0) begin
            if (!div_busy_ff) begin
               div_start = 1'b1; div_busy_in = 1'b1;
               neg_in = sum_ff[26];
               div_dividend = 64'(sum_ff[26] ? -sum_ff : sum_ff) << 1;
               div_dividend = div_dividend + 64'(run_cnt_ff);
               div_divisor = 32'(run_cnt_ff) << 1;
            end else if (div_done) begin
               div_busy_in = 1'b0;
               steady_in = neg_ff ? -16'(div_q) : 16'(div_q);
            end
         end
         ST_RATIO: if (count_ff != '0 && steady_ff != '0) begin
            if (!div_busy_ff) begin
               num = (64'(max_ff) - 64'(steady_ff)) <<< 16;
               if (steady_ff < 0) num = -num;
               neg_in = num[63];
               div_start = 1'b1; div_busy_in = 1'b1;
               div_dividend = ((num[63] ? -num : num) << 1)
                              + 64'(steady_ff < 0 ? -32'(steady_ff) : 32'(steady_ff));
               div_divisor = (steady_ff < 0 ? -32'(steady_ff) : 32'(steady_ff)) << 1;
            end else if (div_done) begin
               div_busy_in = 1'b0;
               q_s = neg_ff ? -$signed(div_q) : $signed(div_q);
               if (q_s > 64'sh7fffffff) oratio_in = 32'sh7fffffff;
               else if (q_s < -64'sh80000000) oratio_in = 32'sh80000000;
               else oratio_in = 32'(q_s);
            end
         end
         ST_BAND: begin
            lo_in = (49'(steady_ff) <<< 16) - 49'(signed'({1'b0, ratio_ff})) * 49'(steady_ff);
            hi_in = (49'(steady_ff) <<< 16) + 49'(signed'({1'b0, ratio_ff})) * 49'(steady_ff);
            idx_in = '0; in_run_in = 1'b0; start_in = '0;
         end
         ST_SCAN, ST_SCAN_LAST: begin
            if (state_ff == ST_SCAN) idx_in = idx_ff + 1'b1;
            if (idx_ff != '0 || state_ff == ST_SCAN_LAST) begin
               if (x > lo_ff && x < hi_ff) begin
                  if (!in_run_ff) begin in_run_in = 1'b1; start_in = time_rd_ff; end
               end else in_run_in = 1'b0;
            end
         end
         ST_OUT: if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_in = 1'b1;
            rsp_in.steady_level = steady_ff;
            rsp_in.overshoot_ratio = oratio_ff;
            rsp_in.overshoot_valid = count_ff != '0 && steady_ff != '0;
            rsp_in.settle_found = (49'(max_ff) <<< 16) > hi_ff && in_run_ff;
            rsp_in.settle_time = rsp_in.settle_found ? start_ff : '0;
            rsp_in.store_overflowed = ovf_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ratio_ff <= BandRatioReset; count_ff <= '0;
         max_ff <= 16'sh8000; sum_ff <= '0; run_cnt_ff <= '0; peak_ff <= 1'b0;
         prev_ff <= '0; slope_ff <= 2'b01; ovf_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         div_busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; max_ff <= max_in;
         sum_ff <= sum_in; run_cnt_ff <= run_cnt_in; peak_ff <= peak_in;
         prev_ff <= prev_in; slope_ff <= slope_in; ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in; div_busy_ff <= div_busy_in;
         if (csr_write) ratio_ff <= csr_data;
      end
      steady_ff <= steady_in; oratio_ff <= oratio_in; lo_ff <= lo_in; hi_ff <= hi_in;
      idx_ff <= idx_in; in_run_ff <= in_run_in; start_ff <= start_in;
      rsp_ff <= rsp_in; neg_ff <= neg_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== rtl/core/srm_checker.sv =====
// Checker: port-level properties of the step response metrics block, bound to the top level.
module srm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input srm_pkg::req_type_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input srm_pkg::rsp_type rsp_data
);
   import srm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type == REQ_QUERY |=> req_stall)
      else $error("query did not block input");

   a_add_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_stall |=> !rsp_valid)
      else $error("response without query");

   a_settle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.settle_found |-> rsp_data.settle_time == '0)
      else $error("settle time without settling");

   a_ratio_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.overshoot_valid |-> rsp_data.overshoot_ratio == '0)
      else $error("ratio without valid");
endmodule

bind step_response_metrics_top srm_checker u_srm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
